// File: hw/rtl/tsh_pkg.sv
`timescale 1ns / 1ps

package tsh_pkg;

	// table geometry
	localparam int BINS       = 4096;
	localparam int COUNT_BITS = 32;
	localparam int SYM_W      = $clog2(BINS);
	localparam int CMP_W      = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	// fixed field widths
	localparam int SYMBOL_W = 12;
	localparam int VALUE_W  = 32;
	localparam int CFG_IDX_W = 2;

	// request codes
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_CUTOFF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CUTOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ZEROS   = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [VALUE_W-1:0] sample_value;
	} req_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic [VALUE_W-1:0]  count;
		logic                is_last;
		logic                done_res;
		logic                range_error;
	} res_t;

endpackage

// File: hw/rtl/trimmed_symbol_histogram.sv
`timescale 1ns / 1ps

// add sample: busy for a table read-modify-write (read state, then write state), no result
// read: result strobe with done when nothing was counted, else one bin or done after a range
//   search (first read after new samples) and skipping of bins at or below display cutoff if zeros are off
// clear request and reset: clearing pass writes zero to all BINS (4096) bins of the table, busy high
// reset is asynchronous, active low; registers default to cutoffs 0, output_zeros 1
// the receiver cannot stall: each result is valid for exactly one cycle
module trimmed_symbol_histogram (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tsh_pkg::req_t                     req,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsh_pkg::VALUE_W-1:0]       cfg_data,
	output logic                              res_valid,
	output tsh_pkg::res_t                     res
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_FF_RD,
		ST_FF_CHK,
		ST_FL_RD,
		ST_FL_CHK,
		ST_SERVE,
		ST_SRV_RD,
		ST_SRV_CHK
	} state_t;

	localparam logic [tsh_pkg::SYM_W-1:0] LAST_BIN = tsh_pkg::SYM_W'(tsh_pkg::BINS - 1);

	state_t                               state_q;
	logic [tsh_pkg::SYM_W-1:0]            addr_q;
	logic [tsh_pkg::SYM_W-1:0]            min_q;
	logic [tsh_pkg::SYM_W-1:0]            max_q;
	logic [tsh_pkg::SYM_W-1:0]            end_q;
	logic [tsh_pkg::SYM_W:0]              cursor_q;
	logic                                 seen_q;
	logic                                 found_q;
	logic                                 dropped_q;
	logic                                 res_valid_q;
	tsh_pkg::res_t                        res_q;

	logic [tsh_pkg::VALUE_W-1:0]          count_cutoff_q;
	logic [tsh_pkg::VALUE_W-1:0]          display_cutoff_q;
	logic                                 output_zeros_q;

	logic [tsh_pkg::COUNT_BITS-1:0]       mem [tsh_pkg::BINS];
	logic [tsh_pkg::COUNT_BITS-1:0]       rd_q;
	logic                                 mem_we;
	logic [tsh_pkg::COUNT_BITS-1:0]       mem_wdata;

	logic                                 accept;
	logic                                 sample_oor;
	logic [tsh_pkg::SYM_W-1:0]            sample_idx;
	logic                                 meets_cut;
	logic                                 above_disp;
	logic                                 past_end;
	logic [tsh_pkg::VALUE_W-1:0]          count_sat;

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// sample decode and count compares
	assign sample_oor = (req.sample_value >= tsh_pkg::VALUE_W'(tsh_pkg::BINS));
	assign sample_idx = req.sample_value[tsh_pkg::SYM_W-1:0];
	assign meets_cut  = (tsh_pkg::CMP_W'(rd_q) >= tsh_pkg::CMP_W'(count_cutoff_q));
	assign above_disp = (tsh_pkg::CMP_W'(rd_q) > tsh_pkg::CMP_W'(display_cutoff_q));
	assign past_end   = (cursor_q > {1'b0, end_q});
	assign count_sat  = (tsh_pkg::CMP_W'(rd_q) > tsh_pkg::CMP_W'({tsh_pkg::VALUE_W{1'b1}}))
		? {tsh_pkg::VALUE_W{1'b1}} : tsh_pkg::VALUE_W'(rd_q);

	// table write: zero during clearing, saturating increment on add
	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || (state_q == ST_ADD_WR);
		mem_wdata = '0;
		if (state_q == ST_ADD_WR) begin
			mem_wdata = (&rd_q) ? rd_q : rd_q + tsh_pkg::COUNT_BITS'(1);
		end
	end

	// count table, one port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wdata;
		end
		rd_q <= mem[addr_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cutoff_q   <= '0;
			display_cutoff_q <= '0;
			output_zeros_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsh_pkg::REG_COUNT_CUTOFF:   count_cutoff_q   <= cfg_data;
				tsh_pkg::REG_DISPLAY_CUTOFF: display_cutoff_q <= cfg_data;
				tsh_pkg::REG_OUTPUT_ZEROS:   output_zeros_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer with tracking state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			min_q       <= LAST_BIN;
			max_q       <= '0;
			end_q       <= '0;
			cursor_q    <= '0;
			seen_q      <= 1'b0;
			found_q     <= 1'b0;
			dropped_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + tsh_pkg::SYM_W'(1);
					if (addr_q == LAST_BIN) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							tsh_pkg::REQ_ADD: begin
								if (sample_oor) begin
									dropped_q <= 1'b1;
								end else begin
									addr_q  <= sample_idx;
									if (!seen_q || sample_idx < min_q) min_q <= sample_idx;
									if (!seen_q || sample_idx > max_q) max_q <= sample_idx;
									seen_q  <= 1'b1;
									found_q <= 1'b0;
									state_q <= ST_ADD_RD;
								end
							end
							tsh_pkg::REQ_READ: begin
								if (!seen_q) begin
									res_valid_q <= 1'b1;
									res_q       <= {{(tsh_pkg::SYMBOL_W + tsh_pkg::VALUE_W + 1){1'b0}},
										1'b1, dropped_q};
								end else if (!found_q) begin
									addr_q  <= min_q;
									state_q <= ST_FF_RD;
								end else begin
									state_q <= ST_SERVE;
								end
							end
							tsh_pkg::REQ_CLEAR: begin
								addr_q    <= '0;
								min_q     <= LAST_BIN;
								max_q     <= '0;
								end_q     <= '0;
								cursor_q  <= '0;
								seen_q    <= 1'b0;
								found_q   <= 1'b0;
								dropped_q <= 1'b0;
								state_q   <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: state_q <= ST_IDLE;
				// walk up from the minimum for the first bin at the cutoff
				ST_FF_RD:  state_q <= ST_FF_CHK;
				ST_FF_CHK: begin
					if (meets_cut) begin
						cursor_q <= {1'b0, addr_q};
						addr_q   <= max_q;
						state_q  <= ST_FL_RD;
					end else if (addr_q == max_q) begin
						end_q    <= '0;
						cursor_q <= (tsh_pkg::SYM_W + 1)'(1);
						found_q  <= 1'b1;
						state_q  <= ST_SERVE;
					end else begin
						addr_q  <= addr_q + tsh_pkg::SYM_W'(1);
						state_q <= ST_FF_RD;
					end
				end
				// walk down from the maximum, stops at the first bin at the latest
				ST_FL_RD:  state_q <= ST_FL_CHK;
				ST_FL_CHK: begin
					if (meets_cut) begin
						end_q   <= addr_q;
						found_q <= 1'b1;
						state_q <= ST_SERVE;
					end else begin
						addr_q  <= addr_q - tsh_pkg::SYM_W'(1);
						state_q <= ST_FL_RD;
					end
				end
				ST_SERVE: begin
					if (past_end) begin
						res_valid_q <= 1'b1;
						res_q       <= {{(tsh_pkg::SYMBOL_W + tsh_pkg::VALUE_W + 1){1'b0}},
							1'b1, dropped_q};
						state_q     <= ST_IDLE;
					end else begin
						addr_q  <= cursor_q[tsh_pkg::SYM_W-1:0];
						state_q <= ST_SRV_RD;
					end
				end
				ST_SRV_RD: state_q <= ST_SRV_CHK;
				// skip bins at or below display cutoff when zeros are suppressed
				ST_SRV_CHK: begin
					cursor_q <= cursor_q + (tsh_pkg::SYM_W + 1)'(1);
					if (!output_zeros_q && !above_disp) begin
						state_q <= ST_SERVE;
					end else begin
						res_valid_q       <= 1'b1;
						res_q.symbol      <= tsh_pkg::SYMBOL_W'(addr_q);
						res_q.count       <= count_sat;
						res_q.is_last     <= (addr_q == end_q);
						res_q.done_res    <= 1'b0;
						res_q.range_error <= dropped_q;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/tsh_checker.sv
`timescale 1ns / 1ps

module tsh_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  tsh_pkg::req_t                     req,
	input  logic                              res_valid,
	input  tsh_pkg::res_t                     res
);

	logic accepted;

	assign accepted = start && !busy;

	// a done answer carries no bin
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> res.symbol == '0 && res.count == '0 && !res.is_last)
		else $error("done result with bin payload");

	// last-bin and done are exclusive
	a_last_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.is_last && res.done_res))
		else $error("result marked both last and done");

	// a result only follows an accepted request or ongoing work
	a_res_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(accepted) || $past(busy))
		else $error("result without pending request");

	// a clear transfer starts the clearing pass and gives no result
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && req.req_type == tsh_pkg::REQ_CLEAR |=> busy && !res_valid)
		else $error("clear request not followed by clearing pass");

endmodule

bind trimmed_symbol_histogram tsh_checker u_tsh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.req       (req),
	.res_valid (res_valid),
	.res       (res)
);

// File: tb/sv/trimmed_symbol_histogram_tb.sv
`timescale 1ns / 1ps

module trimmed_symbol_histogram_tb;

	// codes the package leaves unnamed
	localparam logic [1:0]                    REQ_UNUSED  = 2'd3;
	localparam logic [tsh_pkg::CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
	localparam bit [63:0]  COUNT_CEIL  = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - tsh_pkg::COUNT_BITS);
	localparam logic [31:0]                   WORD_MAX    = 32'hFFFF_FFFF;
	localparam int                            RANDOM_ITEMS = 1750;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	tsh_pkg::req_t                 req;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tsh_pkg::VALUE_W-1:0]   cfg_data;
	logic                          res_valid;
	tsh_pkg::res_t                 res;

	// histogram shadow state
	bit [63:0]   bin_tally [tsh_pkg::BINS];
	int          sym_lo;
	int          sym_hi;
	int          cursor;
	int          span_end;
	bit          any_seen;
	bit          span_fixed;
	bit          dropped;
	logic [31:0] keep_cutoff;
	logic [31:0] show_cutoff;
	bit          show_zeros;

	tsh_pkg::res_t pending_reports [$];
	tsh_pkg::res_t last_report;
	int            mismatches;
	int            items_sent;
	int            gap_max;

	trimmed_symbol_histogram dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.res_valid(res_valid),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#(20_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void wipe_tally();
		foreach (bin_tally[i]) bin_tally[i] = '0;
		sym_lo     = tsh_pkg::BINS - 1;
		sym_hi     = 0;
		any_seen   = 1'b0;
		span_fixed = 1'b0;
		cursor     = 0;
		span_end   = 0;
		dropped    = 1'b0;
	endfunction

	// update the shadow histogram for one accepted request, queue the report of a read
	function automatic void predict_bin_report(tsh_pkg::req_t r);
		int            s;
		int            i;
		int            first;
		int            last;
		bit            found;
		bit [63:0]     c;
		tsh_pkg::res_t rep;
		case (r.req_type)
			tsh_pkg::REQ_ADD: begin
				if (r.sample_value >= tsh_pkg::BINS) begin
					dropped = 1'b1;
				end else begin
					s = r.sample_value;
					if (bin_tally[s] < COUNT_CEIL) bin_tally[s]++;
					if (!any_seen || s < sym_lo) sym_lo = s;
					if (!any_seen || s > sym_hi) sym_hi = s;
					any_seen   = 1'b1;
					span_fixed = 1'b0;
				end
			end
			tsh_pkg::REQ_CLEAR: begin
				wipe_tally();
			end
			tsh_pkg::REQ_READ: begin
				// trim both ends of min..max against the count cutoff
				if (any_seen && !span_fixed) begin
					found = 1'b0;
					first = 0;
					last  = 0;
					for (i = sym_lo; i <= sym_hi; i++) begin
						if (bin_tally[i] >= keep_cutoff) begin
							first = i;
							found = 1'b1;
							break;
						end
					end
					if (found) begin
						for (i = sym_hi; i >= first; i--) begin
							if (bin_tally[i] >= keep_cutoff) begin
								last = i;
								break;
							end
						end
						cursor   = first;
						span_end = last;
					end else begin
						span_end = 0;
						cursor   = 1;
					end
					span_fixed = 1'b1;
				end
				// skip bins at or below the display cutoff
				if (any_seen && !show_zeros) begin
					while (cursor <= span_end && bin_tally[cursor] <= show_cutoff) cursor++;
				end
				rep = '0;
				rep.range_error = dropped;
				if (!any_seen || cursor > span_end) begin
					rep.done_res = 1'b1;
				end else begin
					c = bin_tally[cursor];
					rep.symbol  = cursor[tsh_pkg::SYMBOL_W-1:0];
					rep.count   = (c > 64'(WORD_MAX)) ? WORD_MAX : c[31:0];
					rep.is_last = (cursor == span_end);
					cursor++;
				end
				pending_reports.push_back(rep);
				last_report = rep;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// compare every result strobe against the oldest pending report
	always @(posedge clk) begin : check_reports
		tsh_pkg::res_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: symbol %0d count %0d", res.symbol, res.count);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("symbol", 64'(want.symbol), 64'(res.symbol));
				check_field("count", 64'(want.count), 64'(res.count));
				check_field("is_last", 64'(want.is_last), 64'(res.is_last));
				check_field("done_res", 64'(want.done_res), 64'(res.done_res));
				check_field("range_error", 64'(want.range_error), 64'(res.range_error));
			end
		end
	end

	// one request transfer after a random idle gap
	task automatic send_request(logic [1:0] code, logic [31:0] value);
		tsh_pkg::req_t item;
		int            gap;
		item.req_type     = code;
		item.sample_value = value;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy !== 1'b0);
		predict_bin_report(item);
		if (code != REQ_UNUSED) items_sent++;
	endtask

	// stop sending, drain all reports and let the block settle
	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy !== 1'b0);
		repeat (8) @(posedge clk);
	endtask

	// one register write transfer
	task automatic cfg_write(logic [tsh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			tsh_pkg::REG_COUNT_CUTOFF:   keep_cutoff = data;
			tsh_pkg::REG_DISPLAY_CUTOFF: show_cutoff = data;
			tsh_pkg::REG_OUTPUT_ZEROS:   show_zeros  = data[0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_threshold();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return WORD_MAX;
		if (r == 1) return $urandom;
		return $urandom_range(0, 4);
	endfunction

	// read before any sample arrives
	task automatic test_empty_read();
		send_request(tsh_pkg::REQ_READ, $urandom);
	endtask

	// lowest and highest symbols, dropped samples, unused request code
	task automatic test_symbol_extremes();
		send_request(tsh_pkg::REQ_ADD, 0);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS - 1);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS - 1);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS);
		send_request(tsh_pkg::REQ_ADD, WORD_MAX);
		send_request(REQ_UNUSED, $urandom);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_CLEAR, $urandom);
	endtask

	// display cutoff, count cutoff trimming, empty trimmed ranges
	task automatic test_cutoffs();
		quiesce();
		cfg_write(tsh_pkg::REG_OUTPUT_ZEROS, 0);
		cfg_write(tsh_pkg::REG_DISPLAY_CUTOFF, 0);
		cfg_write(REG_UNUSED, $urandom);
		send_request(tsh_pkg::REQ_ADD, 0);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS - 1);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_READ, $urandom);
		quiesce();
		cfg_write(tsh_pkg::REG_COUNT_CUTOFF, 2);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS - 1);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_READ, $urandom);
		// every bin at or below the display cutoff
		quiesce();
		cfg_write(tsh_pkg::REG_DISPLAY_CUTOFF, WORD_MAX);
		send_request(tsh_pkg::REQ_ADD, tsh_pkg::BINS - 1);
		send_request(tsh_pkg::REQ_READ, $urandom);
		// no bin reaches the count cutoff
		quiesce();
		cfg_write(tsh_pkg::REG_COUNT_CUTOFF, WORD_MAX);
		cfg_write(tsh_pkg::REG_DISPLAY_CUTOFF, 0);
		send_request(tsh_pkg::REQ_ADD, 5);
		send_request(tsh_pkg::REQ_READ, $urandom);
		// same with minimum and maximum on one bin
		send_request(tsh_pkg::REQ_CLEAR, $urandom);
		send_request(tsh_pkg::REQ_ADD, 7);
		send_request(tsh_pkg::REQ_READ, $urandom);
		send_request(tsh_pkg::REQ_CLEAR, $urandom);
	endtask

	// random phases: new settings, a burst of traffic, then a clear
	task automatic test_random_phases();
		int stop_at;
		bit wide;
		int base;
		int w;
		int n;
		int k;
		int j;
		int pick;
		int pool [6];
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			quiesce();
			wide    = ($urandom_range(0, 7) == 0);
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			cfg_write(tsh_pkg::REG_DISPLAY_CUTOFF, pick_threshold());
			cfg_write(tsh_pkg::REG_OUTPUT_ZEROS, $urandom);
			cfg_write(tsh_pkg::REG_COUNT_CUTOFF, wide ? $urandom_range(0, 1) : pick_threshold());
			if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, $urandom);
			if (wide) begin
				// few symbols spread over the whole table, then a run of reads
				foreach (pool[i]) pool[i] = $urandom_range(0, tsh_pkg::BINS - 1);
				if ($urandom_range(0, 1)) pool[0] = 0;
				if ($urandom_range(0, 1)) pool[1] = tsh_pkg::BINS - 1;
				n = $urandom_range(6, 30);
				for (k = 0; k < n; k++) send_request(tsh_pkg::REQ_ADD, pool[$urandom_range(0, 5)]);
				repeat (12) send_request(tsh_pkg::REQ_READ, $urandom);
			end else begin
				case ($urandom_range(0, 5))
					0:       base = 0;
					1:       base = tsh_pkg::BINS - 32;
					default: base = $urandom_range(0, tsh_pkg::BINS - 32);
				endcase
				w = $urandom_range(1, 32);
				n = $urandom_range(20, 60);
				for (k = 0; k < n; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 55) begin
						send_request(tsh_pkg::REQ_ADD, base + $urandom_range(0, w - 1));
					end else if (pick < 78) begin
						send_request(tsh_pkg::REQ_READ, $urandom);
					end else if (pick < 88) begin
						// read the trimmed range out to its end
						j = 0;
						do begin
							send_request(tsh_pkg::REQ_READ, $urandom);
							j++;
						end while (!last_report.done_res && j < 40);
					end else if (pick < 93) begin
						send_request(tsh_pkg::REQ_ADD, $urandom_range(tsh_pkg::BINS, WORD_MAX));
					end else if (pick < 98) begin
						send_request(REQ_UNUSED, $urandom);
					end else begin
						send_request(tsh_pkg::REQ_CLEAR, $urandom);
					end
				end
			end
			send_request(tsh_pkg::REQ_CLEAR, $urandom);
		end
	endtask

	initial begin
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		wipe_tally();
		keep_cutoff = '0;
		show_cutoff = '0;
		show_zeros  = 1'b1;
		mismatches  = 0;
		items_sent  = 0;
		gap_max     = 10;
		last_report = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait out the clearing pass after reset
		quiesce();

		test_empty_read();
		test_symbol_extremes();
		test_cutoffs();
		test_random_phases();

		quiesce();
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: trimmed_symbol_histogram.f
hw/rtl/tsh_pkg.sv
hw/rtl/trimmed_symbol_histogram.sv
hw/rtl/tsh_checker.sv
tb/sv/trimmed_symbol_histogram_tb.sv
